FILE: src/terminal_line_editor_assert.svh
// Assertion macros for the terminal line editor.
// Used by the top level; expects clk_i and rst_ni in scope.
`ifndef TERMINAL_LINE_EDITOR_ASSERT_SVH
`define TERMINAL_LINE_EDITOR_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define TLE_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define TLE_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: src/tle_pkg.sv
// Shared types and constants for the terminal line editor.
// No dependencies; used by the interfaces and all modules.
package tle_pkg;

  typedef logic [7:0] byte_t;
  typedef logic [1:0] cfg_addr_t;

  // Default line capacity.
  localparam int unsigned LineMaxDef = 40;

  // Configuration register indexes.
  localparam cfg_addr_t CfgKill      = 2'd0;
  localparam cfg_addr_t CfgErase     = 2'd1;
  localparam cfg_addr_t CfgWordErase = 2'd2;

  // Register reset values.
  localparam byte_t KillDef      = 8'd21;
  localparam byte_t EraseDef     = 8'd127;
  localparam byte_t WordEraseDef = 8'd23;

  // Character codes.
  localparam byte_t ChBel    = 8'd7;
  localparam byte_t ChLf     = 8'd10;
  localparam byte_t ChCr     = 8'd13;
  localparam byte_t ChEsc    = 8'd27;
  localparam byte_t ChSpace  = 8'd32;
  localparam byte_t ChLbrack = 8'd91;
  localparam byte_t ChUpperK = 8'd75;
  localparam byte_t PrintLo  = 8'd32;
  localparam byte_t PrintHi  = 8'd126;

  // Classification of an incoming key against the control codes.
  typedef struct packed {
    logic is_kill;
    logic is_erase;
    logic is_werase;
    logic is_nl;
    logic is_print;
  } key_class_t;

  // One byte offered by the sequencer to the output register.
  typedef struct packed {
    logic  valid;
    byte_t data;
    logic  last;
  } emit_t;

endpackage

FILE: src/tle_if.sv
// Handshake interfaces for the terminal line editor channels.
// Depends on tle_pkg for the payload types.
interface tle_key_if;
  logic          valid;
  logic          ready;
  tle_pkg::byte_t key_byte;
  modport source (output valid, output key_byte, input ready);
  modport sink   (input valid, input key_byte, output ready);
endinterface

interface tle_echo_if;
  logic          valid;
  logic          ready;
  tle_pkg::byte_t echo_byte;
  logic          run_end;
  modport source (output valid, output echo_byte, output run_end, input ready);
  modport sink   (input valid, input echo_byte, input run_end, output ready);
endinterface

interface tle_cfg_if;
  logic               valid;
  logic               ready;
  tle_pkg::cfg_addr_t addr;
  tle_pkg::byte_t     wdata;
  modport source (output valid, output addr, output wdata, input ready);
  modport sink   (input valid, input addr, input wdata, output ready);
endinterface

FILE: src/tle_line_mem.sv
// Line store: single write port, single registered read port.
// Depends on tle_pkg for the byte type.
module tle_line_mem #(
  parameter int unsigned DEPTH = tle_pkg::LineMaxDef,
  parameter int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic           clk_i,
  input  logic           we_i,
  input  logic [AW-1:0]  waddr_i,
  input  tle_pkg::byte_t wdata_i,
  input  logic [AW-1:0]  raddr_i,
  output tle_pkg::byte_t rdata_o
);
  import tle_pkg::*;

  byte_t mem_q [DEPTH];
  byte_t rdata_q;

  // Write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Read port, data registered.
  always_ff @(posedge clk_i) begin
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

FILE: src/tle_seq.sv
// Sequencer of the line editor: decodes a key, scans the line store for
// word erase and streams the echo bytes. Depends on tle_pkg, tle_line_mem.
module tle_seq #(
  parameter int unsigned LINE_MAX = tle_pkg::LineMaxDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  input  tle_pkg::byte_t      key_byte_i,
  input  tle_pkg::key_class_t cls_i,
  input  logic                slot_free_i,
  output logic                idle_o,
  output tle_pkg::emit_t      emit_o
);
  import tle_pkg::*;

  localparam int unsigned LenW = $clog2(LINE_MAX + 1);
  localparam int unsigned IdxW = (LINE_MAX > 1) ? $clog2(LINE_MAX) : 1;
  localparam logic [LenW-1:0] LenMax = LenW'(LINE_MAX);
  localparam logic [LenW-1:0] LenOne = LenW'(1);
  localparam logic [LenW-1:0] LenTwo = LenW'(2);

  // Sequencer states.
  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_HDR  = 4'd1;
  localparam logic [3:0] S_LINE = 4'd2;
  localparam logic [3:0] S_NLA  = 4'd3;
  localparam logic [3:0] S_NLB  = 4'd4;
  localparam logic [3:0] S_ONE  = 4'd5;
  localparam logic [3:0] S_WS1  = 4'd6;
  localparam logic [3:0] S_WS2  = 4'd7;
  localparam logic [3:0] S_WS3  = 4'd8;

  // Kinds of multi-byte answer.
  localparam logic [1:0] KIND_KILL   = 2'd0;
  localparam logic [1:0] KIND_REDRAW = 2'd1;
  localparam logic [1:0] KIND_NL     = 2'd2;

  // Header position of the final byte of each header.
  localparam logic [2:0] HdrKLast = 3'd4;
  localparam logic [2:0] HdrRLast = 3'd3;

  logic [3:0]      state_q, state_d;
  logic [1:0]      kind_q, kind_d;
  logic [2:0]      hidx_q, hidx_d;
  logic [LenW-1:0] ptr_q, ptr_d;
  logic [LenW-1:0] p_q, p_d;
  logic [LenW-1:0] len_q, len_d;
  byte_t           byte_q, byte_d;
  logic            mem_we;
  byte_t           rdata;
  logic            fire;

  // Clear-line header: CR ESC [ K, then CR for kill.
  function automatic byte_t hdr_byte(input logic [2:0] idx);
    byte_t b;
    unique case (idx)
      3'd0:    b = ChCr;
      3'd1:    b = ChEsc;
      3'd2:    b = ChLbrack;
      3'd3:    b = ChUpperK;
      default: b = ChCr;
    endcase
    return b;
  endfunction

  // The store is read every cycle at the next pointer, so the read data
  // always holds the entry at the current pointer.
  tle_line_mem #(
    .DEPTH (LINE_MAX)
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (len_q[IdxW-1:0]),
    .wdata_i (key_byte_i),
    .raddr_i (ptr_d[IdxW-1:0]),
    .rdata_o (rdata)
  );

  assign fire   = emit_o.valid && slot_free_i;
  assign idle_o = (state_q == S_IDLE);

  // Next-state and output logic.
  always_comb begin
    state_d = state_q;
    kind_d  = kind_q;
    hidx_d  = hidx_q;
    ptr_d   = ptr_q;
    p_d     = p_q;
    len_d   = len_q;
    byte_d  = byte_q;
    mem_we  = 1'b0;
    emit_o  = '0;
    unique case (state_q)
      S_IDLE: begin
        if (start_i) begin
          priority if (cls_i.is_kill) begin
            len_d   = '0;
            kind_d  = KIND_KILL;
            hidx_d  = '0;
            ptr_d   = '0;
            state_d = S_HDR;
          end else if (cls_i.is_erase) begin
            if (len_q != '0) begin
              len_d   = len_q - LenOne;
              kind_d  = KIND_REDRAW;
              hidx_d  = '0;
              ptr_d   = '0;
              state_d = S_HDR;
            end
          end else if (cls_i.is_werase) begin
            if (len_q == '0) begin
              p_d     = '0;
              ptr_d   = '0;
              state_d = S_WS3;
            end else begin
              p_d     = len_q;
              ptr_d   = len_q - LenOne;
              state_d = S_WS1;
            end
          end else if (cls_i.is_nl) begin
            kind_d  = KIND_NL;
            ptr_d   = '0;
            state_d = S_NLA;
          end else if (cls_i.is_print) begin
            if (len_q != LenMax) begin
              mem_we  = 1'b1;
              len_d   = len_q + LenOne;
              byte_d  = key_byte_i;
              state_d = S_ONE;
            end else begin
              kind_d  = KIND_NL;
              ptr_d   = '0;
              state_d = S_NLA;
            end
          end else begin
            byte_d  = ChBel;
            state_d = S_ONE;
          end
        end
      end
      // Back over trailing spaces; the read data is the entry below p.
      S_WS1: begin
        if (rdata == ChSpace) begin
          p_d = p_q - LenOne;
          if (p_q == LenOne) begin
            ptr_d   = '0;
            state_d = S_WS3;
          end else begin
            ptr_d = p_q - LenTwo;
          end
        end else begin
          state_d = S_WS2;
        end
      end
      // Back over one word.
      S_WS2: begin
        if (rdata != ChSpace) begin
          p_d = p_q - LenOne;
          if (p_q == LenOne) begin
            ptr_d   = '0;
            state_d = S_WS3;
          end else begin
            ptr_d = p_q - LenTwo;
          end
        end else begin
          ptr_d   = p_q;
          state_d = S_WS3;
        end
      end
      // Re-advance over spaces; the read data is the entry at p.
      S_WS3: begin
        if ((p_q != len_q) && (rdata == ChSpace)) begin
          p_d   = p_q + LenOne;
          ptr_d = p_q + LenOne;
        end else begin
          len_d   = p_q;
          kind_d  = KIND_REDRAW;
          hidx_d  = '0;
          ptr_d   = '0;
          state_d = S_HDR;
        end
      end
      S_HDR: begin
        emit_o.valid = 1'b1;
        emit_o.data  = hdr_byte(hidx_q);
        emit_o.last  = ((kind_q == KIND_KILL) && (hidx_q == HdrKLast)) ||
                       ((kind_q == KIND_REDRAW) && (hidx_q == HdrRLast) && (len_q == '0));
        if (fire) begin
          hidx_d = hidx_q + 3'd1;
          if ((kind_q == KIND_KILL) && (hidx_q == HdrKLast)) begin
            state_d = S_IDLE;
          end else if ((kind_q != KIND_KILL) && (hidx_q == HdrRLast)) begin
            state_d = (len_q == '0) ? S_IDLE : S_LINE;
          end
        end
      end
      S_LINE: begin
        emit_o.valid = 1'b1;
        emit_o.data  = rdata;
        emit_o.last  = (kind_q == KIND_REDRAW) && ((ptr_q + LenOne) == len_q);
        if (fire) begin
          ptr_d = ptr_q + LenOne;
          if ((ptr_q + LenOne) == len_q) begin
            state_d = (kind_q == KIND_REDRAW) ? S_IDLE : S_NLB;
          end
        end
      end
      S_NLA: begin
        emit_o.valid = 1'b1;
        emit_o.data  = ChLf;
        if (fire) begin
          state_d = (len_q == '0) ? S_NLB : S_LINE;
        end
      end
      S_NLB: begin
        emit_o.valid = 1'b1;
        emit_o.data  = ChLf;
        emit_o.last  = 1'b1;
        if (fire) begin
          len_d   = '0;
          state_d = S_IDLE;
        end
      end
      S_ONE: begin
        emit_o.valid = 1'b1;
        emit_o.data  = byte_q;
        emit_o.last  = 1'b1;
        if (fire) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      len_q   <= '0;
    end else begin
      state_q <= state_d;
      len_q   <= len_d;
    end
  end

  // Working registers.
  always_ff @(posedge clk_i) begin
    kind_q <= kind_d;
    hidx_q <= hidx_d;
    ptr_q  <= ptr_d;
    p_q    <= p_d;
    byte_q <= byte_d;
  end

endmodule

FILE: src/terminal_line_editor.sv
// Terminal line editor: one key per input transaction, echo bytes out.
// A key is decoded when it is taken, then its echo bytes are sent; word erase
// first scans the store, character by character. A new key is taken only while
// the sequencer is idle, once the previous key's last echo byte is registered.
// The single read port of the store sets one byte per cycle while the output
// is taken. Reset clears the line length and restores the register defaults.
module terminal_line_editor #(
  parameter int unsigned LINE_MAX = tle_pkg::LineMaxDef
) (
  input  logic clk_i,
  input  logic rst_ni,
  tle_key_if.sink    key_i,
  tle_cfg_if.sink    cfg_i,
  tle_echo_if.source echo_o
);
  import tle_pkg::*;

  byte_t      kill_q, erase_q, werase_q;
  key_class_t cls;
  emit_t      emit;
  logic       slot_free;
  logic       seq_idle;
  logic       key_acc;
  logic       fire;
  logic       ovalid_q;
  byte_t      obyte_q;
  logic       oend_q;

  // Configuration writes are always taken; an unknown index is ignored.
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      kill_q   <= KillDef;
      erase_q  <= EraseDef;
      werase_q <= WordEraseDef;
    end else if (cfg_i.valid) begin
      unique case (cfg_i.addr)
        CfgKill:      kill_q   <= cfg_i.wdata;
        CfgErase:     erase_q  <= cfg_i.wdata;
        CfgWordErase: werase_q <= cfg_i.wdata;
        default: ;
      endcase
    end
  end

  // Key classification; the sequencer applies the priority order.
  always_comb begin
    cls.is_kill   = (key_i.key_byte == kill_q);
    cls.is_erase  = (key_i.key_byte == erase_q);
    cls.is_werase = (key_i.key_byte == werase_q);
    cls.is_nl     = (key_i.key_byte == ChLf) || (key_i.key_byte == ChCr);
    cls.is_print  = (key_i.key_byte >= PrintLo) && (key_i.key_byte <= PrintHi);
  end

  assign key_i.ready = seq_idle;
  assign key_acc     = key_i.valid && seq_idle;

  tle_seq #(
    .LINE_MAX (LINE_MAX)
  ) u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (key_acc),
    .key_byte_i  (key_i.key_byte),
    .cls_i       (cls),
    .slot_free_i (slot_free),
    .idle_o      (seq_idle),
    .emit_o      (emit)
  );

  // Output register: loads when empty or when its transaction completes.
  assign slot_free = !ovalid_q || echo_o.ready;
  assign fire      = emit.valid && slot_free;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ovalid_q <= 1'b0;
    end else if (fire) begin
      ovalid_q <= 1'b1;
    end else if (echo_o.ready) begin
      ovalid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      obyte_q <= emit.data;
      oend_q  <= emit.last;
    end
  end

  assign echo_o.valid     = ovalid_q;
  assign echo_o.echo_byte = obyte_q;
  assign echo_o.run_end   = oend_q;

`include "terminal_line_editor_assert.svh"

  // The sequencer offers no byte while it is waiting for a key.
  `TLE_ASSERT_SAME(a_idle_no_emit, seq_idle, !emit.valid, "byte offered while idle")
  // A stalled byte from the sequencer is held until the register takes it.
  `TLE_ASSERT_NEXT(a_emit_hold, emit.valid && !slot_free,
                   emit.valid && $stable(emit.data) && $stable(emit.last),
                   "stalled echo byte changed")
  // No key is taken while a byte is on offer.
  `TLE_ASSERT_SAME(a_busy_no_key, emit.valid, !key_i.ready, "key ready during output")

endmodule
